/* rtl/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// Lane numbering and counts shared by the matrix-to-quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // One square-root lane per quaternion component
    localparam int N_LANES = 4;
    localparam int N_ELEMS = 9;

    localparam int LANE_W = 0;
    localparam int LANE_X = 1;
    localparam int LANE_Y = 2;
    localparam int LANE_Z = 3;

    // Element positions inside a matrix request, row major
    localparam int E_00 = 0;
    localparam int E_01 = 1;
    localparam int E_02 = 2;
    localparam int E_10 = 3;
    localparam int E_11 = 4;
    localparam int E_12 = 5;
    localparam int E_20 = 6;
    localparam int E_21 = 7;
    localparam int E_22 = 8;

endpackage

/* rtl/rmq_front.sv */
// ----------------------------------------------------------------------------
// rmq_front
// Forms the four diagonal sums, clamps negative ones to zero, scales them
// into square-root radicands and captures the signs of the off-diagonal
// differences.
// ----------------------------------------------------------------------------
module rmq_front #(
    parameter int FRAC_BITS  = 14,
    parameter int ELEM_WIDTH = 16,
    parameter int RAD2_W     = 30
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  logic                                                 i_valid,
    output logic                                                 o_ready,
    input  logic [rmq_pkg::N_ELEMS-1:0][ELEM_WIDTH-1:0]          i_elem,
    output logic                                                 o_valid,
    input  logic                                                 i_ready,
    output logic [rmq_pkg::N_LANES-1:0][RAD2_W-1:0]              o_rad,
    output logic [rmq_pkg::N_LANES-1:0]                          o_neg
);

    localparam int SUM_W  = ((FRAC_BITS > ELEM_WIDTH) ? FRAC_BITS : ELEM_WIDTH) + 3;
    localparam int DIFF_W = ELEM_WIDTH + 1;

    logic signed [ELEM_WIDTH-1:0] a [rmq_pkg::N_ELEMS];
    logic signed [SUM_W-1:0]      one;
    logic signed [SUM_W-1:0]      sum [rmq_pkg::N_LANES];
    logic signed [DIFF_W-1:0]     dx, dy, dz;

    logic                                     r_valid;
    logic [rmq_pkg::N_LANES-1:0][RAD2_W-1:0]  r_rad, n_rad;
    logic [rmq_pkg::N_LANES-1:0]              r_neg, n_neg;

    always_comb begin
        for (int e = 0; e < rmq_pkg::N_ELEMS; e++) begin
            a[e] = i_elem[e];
        end
    end

    assign one = SUM_W'(1) <<< FRAC_BITS;

    assign sum[rmq_pkg::LANE_W] = one + SUM_W'(a[rmq_pkg::E_00]) + SUM_W'(a[rmq_pkg::E_11])
                                + SUM_W'(a[rmq_pkg::E_22]);
    assign sum[rmq_pkg::LANE_X] = one + SUM_W'(a[rmq_pkg::E_00]) - SUM_W'(a[rmq_pkg::E_11])
                                - SUM_W'(a[rmq_pkg::E_22]);
    assign sum[rmq_pkg::LANE_Y] = one - SUM_W'(a[rmq_pkg::E_00]) + SUM_W'(a[rmq_pkg::E_11])
                                - SUM_W'(a[rmq_pkg::E_22]);
    assign sum[rmq_pkg::LANE_Z] = one - SUM_W'(a[rmq_pkg::E_00]) - SUM_W'(a[rmq_pkg::E_11])
                                + SUM_W'(a[rmq_pkg::E_22]);

    assign dx = DIFF_W'(a[rmq_pkg::E_21]) - DIFF_W'(a[rmq_pkg::E_12]);
    assign dy = DIFF_W'(a[rmq_pkg::E_02]) - DIFF_W'(a[rmq_pkg::E_20]);
    assign dz = DIFF_W'(a[rmq_pkg::E_10]) - DIFF_W'(a[rmq_pkg::E_01]);

    always_comb begin
        for (int l = 0; l < rmq_pkg::N_LANES; l++) begin
            // clamp a negative sum to a zero radicand
            if (sum[l][SUM_W-1]) begin
                n_rad[l] = '0;
            end else begin
                n_rad[l] = RAD2_W'(sum[l][SUM_W-2:0]) << (FRAC_BITS - 2);
            end
        end
        n_neg                  = '0;
        n_neg[rmq_pkg::LANE_X] = dx[DIFF_W-1];
        n_neg[rmq_pkg::LANE_Y] = dy[DIFF_W-1];
        n_neg[rmq_pkg::LANE_Z] = dz[DIFF_W-1];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rad <= n_rad;
            r_neg <= n_neg;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_neg   = r_neg;

endmodule

/* rtl/rmq_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// One digit of a restoring square root for all four lanes: brings down the
// next two radicand bits, tries the subtraction and shifts one root bit in.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell #(
    parameter int RT_W = 15
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  logic [rmq_pkg::N_LANES-1:0][2*RT_W-1:0]       i_rad,
    input  logic [rmq_pkg::N_LANES-1:0][RT_W+1:0]         i_rem,
    input  logic [rmq_pkg::N_LANES-1:0][RT_W-1:0]         i_root,
    input  logic [rmq_pkg::N_LANES-1:0]                   i_neg,
    output logic                                          o_valid,
    input  logic                                          i_ready,
    output logic [rmq_pkg::N_LANES-1:0][2*RT_W-1:0]       o_rad,
    output logic [rmq_pkg::N_LANES-1:0][RT_W+1:0]         o_rem,
    output logic [rmq_pkg::N_LANES-1:0][RT_W-1:0]         o_root,
    output logic [rmq_pkg::N_LANES-1:0]                   o_neg
);

    localparam int RAD2_W = 2 * RT_W;
    localparam int REM_W  = RT_W + 2;

    logic [rmq_pkg::N_LANES-1:0][REM_W-1:0]  rem_sh, trial;
    logic [rmq_pkg::N_LANES-1:0][RAD2_W-1:0] n_rad, r_rad;
    logic [rmq_pkg::N_LANES-1:0][REM_W-1:0]  n_rem, r_rem;
    logic [rmq_pkg::N_LANES-1:0][RT_W-1:0]   n_root, r_root;
    logic [rmq_pkg::N_LANES-1:0]             r_neg;
    logic                                    r_valid;

    always_comb begin
        for (int l = 0; l < rmq_pkg::N_LANES; l++) begin
            rem_sh[l] = {i_rem[l][REM_W-3:0], i_rad[l][RAD2_W-1 -: 2]};
            trial[l]  = {i_root[l], 2'b01};
            n_rad[l]  = i_rad[l] << 2;
            if (rem_sh[l] >= trial[l]) begin
                n_rem[l]  = rem_sh[l] - trial[l];
                n_root[l] = {i_root[l][RT_W-2:0], 1'b1};
            end else begin
                n_rem[l]  = rem_sh[l];
                n_root[l] = {i_root[l][RT_W-2:0], 1'b0};
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_neg  <= i_neg;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_neg   = r_neg;

endmodule

/* rtl/rmq_out.sv */
// ----------------------------------------------------------------------------
// rmq_out
// Saturates the four roots, applies the copied signs and holds the
// finished quaternion in the output register.
// ----------------------------------------------------------------------------
module rmq_out #(
    parameter int ELEM_WIDTH = 16,
    parameter int RT_W       = 15
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  logic [rmq_pkg::N_LANES-1:0][RT_W-1:0]      i_root,
    input  logic [rmq_pkg::N_LANES-1:0]                i_neg,
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output logic [ELEM_WIDTH-2:0]                      o_quat_w,
    output logic [ELEM_WIDTH-1:0]                      o_quat_x,
    output logic [ELEM_WIDTH-1:0]                      o_quat_y,
    output logic [ELEM_WIDTH-1:0]                      o_quat_z
);

    localparam int MAG_W = ELEM_WIDTH - 1;
    localparam int EXT_W = (RT_W > ELEM_WIDTH) ? RT_W : ELEM_WIDTH;

    logic [EXT_W-1:0]                                ext_root [rmq_pkg::N_LANES];
    logic [EXT_W-1:0]                                mag_max;
    logic [rmq_pkg::N_LANES-1:0][MAG_W-1:0]          mag;
    logic [rmq_pkg::N_LANES-1:0][ELEM_WIDTH-1:0]     signed_val;

    logic                  r_valid;
    logic [MAG_W-1:0]      r_quat_w;
    logic [ELEM_WIDTH-1:0] r_quat_x, r_quat_y, r_quat_z;

    assign mag_max = EXT_W'({MAG_W{1'b1}});

    always_comb begin
        for (int l = 0; l < rmq_pkg::N_LANES; l++) begin
            ext_root[l] = EXT_W'(i_root[l]);
            if (ext_root[l] > mag_max) begin
                mag[l] = {MAG_W{1'b1}};
            end else begin
                mag[l] = ext_root[l][MAG_W-1:0];
            end
            if (i_neg[l]) begin
                signed_val[l] = ELEM_WIDTH'(0) - {1'b0, mag[l]};
            end else begin
                signed_val[l] = {1'b0, mag[l]};
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_quat_w <= mag[rmq_pkg::LANE_W];
            r_quat_x <= signed_val[rmq_pkg::LANE_X];
            r_quat_y <= signed_val[rmq_pkg::LANE_Y];
            r_quat_z <= signed_val[rmq_pkg::LANE_Z];
        end
    end

    assign o_valid  = r_valid;
    assign o_quat_w = r_quat_w;
    assign o_quat_x = r_quat_x;
    assign o_quat_y = r_quat_y;
    assign o_quat_z = r_quat_z;

endmodule

/* rtl/rotation_matrix_to_quaternion.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix into a unit quaternion with copied signs.
//
// Input stream (s_axis): one request per matrix, nine signed elements with
// FRAC_BITS fraction bits, m_00 in the lowest bits of tdata, row major.
// Output stream (m_axis): one quaternion per matrix, w unsigned, then x, y,
// z signed, all with FRAC_BITS fraction bits.
// Throughput: one matrix per cycle unless m_axis_tready holds the pipeline.
// Each square-root digit has a cell of its own in a row of RT_W cells, all
// four components side by side. Registers from acceptance to tvalid: the
// sum stage, the RT_W root cells and the output register.
// Every stage holds its own valid bit, so empty slots are filled while the
// output stalls; a full pipeline holds everything until m_axis_tready.
// Reset clears only the valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS  = 14,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // m_00, m_01, m_02, m_10, m_11, m_12, m_20, m_21, m_22, zero fill
    input  logic [((9*ELEM_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, zero fill
    output logic [((4*ELEM_WIDTH-1+7)/8)*8-1:0]    m_axis_tdata
);

    localparam int SUM_W    = ((FRAC_BITS > ELEM_WIDTH) ? FRAC_BITS : ELEM_WIDTH) + 3;
    localparam int RAD_W    = SUM_W - 1 + FRAC_BITS - 2;
    localparam int RT_W     = (RAD_W + 1) / 2;
    localparam int RAD2_W   = 2 * RT_W;
    localparam int REM_W    = RT_W + 2;
    localparam int IN_W     = rmq_pkg::N_ELEMS * ELEM_WIDTH;
    localparam int OUT_W    = 4 * ELEM_WIDTH - 1;
    localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8;

    logic [rmq_pkg::N_ELEMS-1:0][ELEM_WIDTH-1:0] elem;

    logic [RT_W:0]                                        c_valid;
    logic [RT_W:0]                                        c_ready;
    logic [RT_W:0][rmq_pkg::N_LANES-1:0][RAD2_W-1:0]      c_rad;
    logic [RT_W:0][rmq_pkg::N_LANES-1:0][REM_W-1:0]       c_rem;
    logic [RT_W:0][rmq_pkg::N_LANES-1:0][RT_W-1:0]        c_root;
    logic [RT_W:0][rmq_pkg::N_LANES-1:0]                  c_neg;

    logic [ELEM_WIDTH-2:0] quat_w;
    logic [ELEM_WIDTH-1:0] quat_x, quat_y, quat_z;

    assign elem = s_axis_tdata[IN_W-1:0];

    rmq_front #(
        .FRAC_BITS  (FRAC_BITS),
        .ELEM_WIDTH (ELEM_WIDTH),
        .RAD2_W     (RAD2_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_elem  (elem),
        .o_valid (c_valid[0]),
        .i_ready (c_ready[0]),
        .o_rad   (c_rad[0]),
        .o_neg   (c_neg[0])
    );

    // the first cell starts from an empty remainder and root
    assign c_rem[0]  = '0;
    assign c_root[0] = '0;

    for (genvar k = 0; k < RT_W; k++) begin : g_cell
        rmq_sqrt_cell #(
            .RT_W (RT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_rad   (c_rad[k]),
            .i_rem   (c_rem[k]),
            .i_root  (c_root[k]),
            .i_neg   (c_neg[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_rad   (c_rad[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_root  (c_root[k+1]),
            .o_neg   (c_neg[k+1])
        );
    end

    rmq_out #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .RT_W       (RT_W)
    ) u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (c_valid[RT_W]),
        .o_ready  (c_ready[RT_W]),
        .i_root   (c_root[RT_W]),
        .i_neg    (c_neg[RT_W]),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_quat_w (quat_w),
        .o_quat_x (quat_x),
        .o_quat_y (quat_y),
        .o_quat_z (quat_z)
    );

    assign m_axis_tdata = OUT_TD_W'({quat_z, quat_y, quat_x, quat_w});

endmodule
